### sv/bba_pkg.sv
package bba_pkg;

	localparam int MAX_BLOCKS = 32768;
	localparam int WORD_BITS  = 32;
	localparam int NUM_WORDS  = (MAX_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W     = $clog2(NUM_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int BLK_W      = ADDR_W + BIT_W;
	localparam int LIM_W      = $clog2(MAX_BLOCKS + 1);

	localparam int FUNC_W     = 2;
	localparam int ID_W       = 15;
	localparam int FDB_W      = 15;
	localparam int TOT_W      = 16;
	localparam int RB_W       = 15;
	localparam int OUT_W      = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam int CMP_W      = (TOT_W > LIM_W ? TOT_W : LIM_W) + 1;

	localparam logic [FDB_W-1:0] FDB_RESET = FDB_W'(12);
	localparam logic [TOT_W-1:0] TOT_RESET = TOT_W'(32768);

	typedef enum logic [FUNC_W-1:0] {
		FN_ALLOC = 2'd0,
		FN_FREE  = 2'd1,
		FN_QUERY = 2'd2,
		FN_NONE  = 2'd3
	} func_t;

	typedef enum logic [OUT_W-1:0] {
		OC_OK        = 2'd0,
		OC_FULL      = 2'd1,
		OC_RANGE     = 2'd2,
		OC_NOT_ALLOC = 2'd3
	} outcome_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_DATA = 1'd0,
		REG_TOTAL      = 1'd1
	} reg_idx_t;

	typedef struct packed {
		logic clr;
		logic take;
		logic scan;
		logic fin_empty;
		logic fin_alloc;
		logic fin_fq;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic empty;
		logic hit;
		logic last_word;
		logic out_free;
	} sts_t;

endpackage

### sv/bba_ctrl.sv
module bba_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [bba_pkg::FUNC_W-1:0] func,
	output logic                       in_stall,
	input  bba_pkg::sts_t              sts,
	output bba_pkg::cmd_t              cmd
);
	import bba_pkg::*;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_CHECK = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
				if (sts.clr_last)
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					cmd.take = 1'b1;
					if (func_t'(func) == FN_ALLOC) begin
						if (sts.empty) begin
							cmd.fin_empty = 1'b1;
							state_d       = ST_DONE;
						end else begin
							state_d = ST_SCAN;
						end
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_CHECK: begin
				cmd.fin_fq = 1'b1;
				state_d    = ST_DONE;
			end
			ST_SCAN: begin
				if (sts.hit || sts.last_word) begin
					cmd.fin_alloc = 1'b1;
					state_d       = ST_DONE;
				end else begin
					cmd.scan = 1'b1;
				end
			end
			ST_DONE: begin
				if (sts.out_free) begin
					cmd.load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

endmodule

### sv/bba_dpath.sv
module bba_dpath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bba_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic [bba_pkg::FUNC_W-1:0]     func,
	input  logic [bba_pkg::ID_W-1:0]       blk_num,
	input  logic                           out_stall,
	input  bba_pkg::cmd_t                  cmd,
	output bba_pkg::sts_t                  sts,
	output logic                           out_valid,
	output logic [bba_pkg::RB_W-1:0]       result_block,
	output logic                           used_bit,
	output logic [bba_pkg::OUT_W-1:0]      outcome
);
	import bba_pkg::*;

	logic [WORD_BITS-1:0] mem [NUM_WORDS];
	logic [WORD_BITS-1:0] rdata_q;

	logic [FDB_W-1:0]  fdb_q;
	logic [TOT_W-1:0]  total_q;
	logic [ADDR_W-1:0] clr_addr_q;
	logic [ADDR_W-1:0] chk_addr_q;
	func_t             func_q;
	logic [ID_W-1:0]   id_q;

	logic [RB_W-1:0]   res_block_q;
	logic              res_used_q;
	outcome_t          res_out_q;
	logic              out_vld_q;
	logic [RB_W-1:0]   out_block_q;
	logic              out_used_q;
	logic [OUT_W-1:0]  out_code_q;

	logic [LIM_W-1:0]     lim;
	logic [BLK_W-1:0]     lim_m1_b;
	logic [BLK_W-1:0]     fdb_b;
	logic [BLK_W-1:0]     in_id_b;
	logic [BLK_W-1:0]     id_b;
	logic                 empty;
	logic                 free_range_bad;
	logic                 query_range_bad;
	logic [WORD_BITS-1:0] lo_force;
	logic [WORD_BITS-1:0] hi_force;
	logic [WORD_BITS-1:0] masked;
	logic                 hit;
	logic [BIT_W-1:0]     hit_bit;
	logic                 id_bit_val;
	logic [ADDR_W-1:0]    rd_addr;
	logic                 we;
	logic [ADDR_W-1:0]    wa;
	logic [WORD_BITS-1:0] wd;

	always_comb begin
		if (CMP_W'(total_q) > CMP_W'(MAX_BLOCKS))
			lim = LIM_W'(MAX_BLOCKS);
		else
			lim = LIM_W'(total_q);
	end

	assign empty    = CMP_W'(fdb_q) >= CMP_W'(lim);
	assign lim_m1_b = BLK_W'(lim - LIM_W'(1));
	assign fdb_b    = BLK_W'(fdb_q);
	assign in_id_b  = BLK_W'(blk_num);
	assign id_b     = BLK_W'(id_q);

	assign free_range_bad  = (CMP_W'(id_q) < CMP_W'(fdb_q)) || (CMP_W'(id_q) >= CMP_W'(lim));
	assign query_range_bad = CMP_W'(id_q) >= CMP_W'(MAX_BLOCKS);

	// Blocks outside the data region count as used in the edge words.
	assign lo_force = (chk_addr_q == fdb_b[BLK_W-1:BIT_W]) ?
		~({WORD_BITS{1'b1}} << fdb_b[BIT_W-1:0]) : '0;
	assign hi_force = (chk_addr_q == lim_m1_b[BLK_W-1:BIT_W]) ?
		(({WORD_BITS{1'b1}} << 1) << lim_m1_b[BIT_W-1:0]) : '0;
	assign masked   = rdata_q | lo_force | hi_force;

	always_comb begin
		hit     = 1'b0;
		hit_bit = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!masked[i]) begin
				hit     = 1'b1;
				hit_bit = BIT_W'(i);
			end
		end
	end

	assign id_bit_val = rdata_q[id_b[BIT_W-1:0]];

	assign sts.clr_last  = (clr_addr_q == ADDR_W'(NUM_WORDS - 1));
	assign sts.empty     = empty;
	assign sts.hit       = hit;
	assign sts.last_word = (chk_addr_q == lim_m1_b[BLK_W-1:BIT_W]);
	assign sts.out_free  = !out_vld_q || !out_stall;

	always_comb begin
		if (cmd.take)
			rd_addr = (func_t'(func) == FN_ALLOC) ? fdb_b[BLK_W-1:BIT_W]
			                                      : in_id_b[BLK_W-1:BIT_W];
		else if (cmd.scan)
			rd_addr = chk_addr_q + ADDR_W'(1);
		else
			rd_addr = chk_addr_q;
	end

	always_comb begin
		we = 1'b0;
		wa = chk_addr_q;
		wd = rdata_q;
		if (cmd.clr) begin
			we = 1'b1;
			wa = clr_addr_q;
			wd = '0;
		end else if (cmd.fin_alloc && hit) begin
			we = 1'b1;
			wd = rdata_q | (WORD_BITS'(1) << hit_bit);
		end else if (cmd.fin_fq && func_q == FN_FREE && !free_range_bad && id_bit_val) begin
			we = 1'b1;
			wd = rdata_q & ~(WORD_BITS'(1) << id_b[BIT_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[wa] <= wd;
		rdata_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fdb_q   <= FDB_RESET;
			total_q <= TOT_RESET;
		end else if (wr_en) begin
			unique case (reg_idx_t'(wr_index))
				REG_FIRST_DATA: fdb_q   <= wr_data[FDB_W-1:0];
				REG_TOTAL:      total_q <= wr_data[TOT_W-1:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			clr_addr_q <= '0;
		else if (cmd.clr)
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			func_q     <= func_t'(func);
			id_q       <= blk_num;
			chk_addr_q <= rd_addr;
		end else if (cmd.scan) begin
			chk_addr_q <= rd_addr;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin_empty) begin
			res_block_q <= '0;
			res_used_q  <= 1'b0;
			res_out_q   <= OC_FULL;
		end else if (cmd.fin_alloc) begin
			res_used_q <= 1'b0;
			if (hit) begin
				res_block_q <= RB_W'({chk_addr_q, hit_bit});
				res_out_q   <= OC_OK;
			end else begin
				res_block_q <= '0;
				res_out_q   <= OC_FULL;
			end
		end else if (cmd.fin_fq) begin
			res_block_q <= '0;
			res_used_q  <= 1'b0;
			res_out_q   <= OC_OK;
			unique case (func_q)
				FN_FREE: begin
					if (free_range_bad)
						res_out_q <= OC_RANGE;
					else if (!id_bit_val)
						res_out_q <= OC_NOT_ALLOC;
				end
				FN_QUERY: begin
					if (query_range_bad)
						res_out_q <= OC_RANGE;
					else
						res_used_q <= id_bit_val;
				end
				FN_ALLOC, FN_NONE: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_vld_q <= 1'b0;
		else if (cmd.load)
			out_vld_q <= 1'b1;
		else if (!out_stall)
			out_vld_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_block_q <= res_block_q;
			out_used_q  <= res_used_q;
			out_code_q  <= res_out_q;
		end
	end

	assign out_valid    = out_vld_q;
	assign result_block = out_block_q;
	assign used_bit     = out_used_q;
	assign outcome      = out_code_q;

endmodule

### sv/block_bitmap_allocator.sv
// channel  dir  handshake            payload
// in       in   in_valid / in_stall  func, blk_num
// out      out  out_valid / out_stall result_block, used_bit, outcome
// cfg      in   wr_en                wr_index, wr_data
//
// Free and query take the input and go through the CHECK and DONE states; the result is
// loaded into the output register from DONE once it is free. Allocate, unless the data
// region is empty, walks the bitmap one word per cycle from the first data word until
// a free bit or the last data word is found. After reset a clearing pass writes every
// one of the NUM_WORDS (1024) bitmap words with in_stall high. One item is in work at
// a time; the next is taken while the result waits in the output register.
module block_bitmap_allocator (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [bba_pkg::CFG_IDX_W-1:0]  wr_index,
	input  logic [bba_pkg::CFG_DATA_W-1:0] wr_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [bba_pkg::FUNC_W-1:0]     func,
	input  logic [bba_pkg::ID_W-1:0]       blk_num,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [bba_pkg::RB_W-1:0]       result_block,
	output logic                           used_bit,
	output logic [bba_pkg::OUT_W-1:0]      outcome
);
	import bba_pkg::*;

	cmd_t cmd;
	sts_t sts;

	bba_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	bba_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.wr_en        (wr_en),
		.wr_index     (wr_index),
		.wr_data      (wr_data),
		.func         (func),
		.blk_num      (blk_num),
		.out_stall    (out_stall),
		.cmd          (cmd),
		.sts          (sts),
		.out_valid    (out_valid),
		.result_block (result_block),
		.used_bit     (used_bit),
		.outcome      (outcome)
	);

endmodule
